// ----- rtl/core/cubic_bezier_easing_interpolator_assert.svh -----
// Assertion macros shared by the checker.
`ifndef CUBIC_BEZIER_EASING_INTERPOLATOR_ASSERT_SVH
`define CUBIC_BEZIER_EASING_INTERPOLATOR_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define CBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CBE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cbe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cbe_pkg;
    localparam int unsigned RegW = 17;
    localparam int unsigned IdxW = 2;
    localparam logic [IdxW-1:0] RegX1 = 2'd0;
    localparam logic [IdxW-1:0] RegY1 = 2'd1;
    localparam logic [IdxW-1:0] RegX2 = 2'd2;
    localparam logic [IdxW-1:0] RegY2 = 2'd3;
    localparam logic [RegW-1:0] ResetX1 = 17'd5636;
    localparam logic [RegW-1:0] ResetY1 = 17'd57344;
    localparam logic [RegW-1:0] ResetX2 = 17'd19923;
    localparam logic [RegW-1:0] ResetY2 = 17'd65536;
endpackage
`default_nettype wire

// ----- rtl/core/cubic_bezier_easing_interpolator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel    Direction  tdata fields (low bit up)                         tuser/tlast
// s_axis     in         elapsed_ms[31:0] duration_ms[62:32]
//                       start[94:63] end[126:95], pad to 128               none
// m_axis     out        eased_value[31:0]                                  none
// cfg        in         i_cfg_we, i_cfg_idx (0..3), i_cfg_data[16:0]       -
// An item that finishes early (elapsed <= 0 or >= duration) goes from the check state
// S_CHK straight to S_OUT and offers its result there.
// Otherwise u is found by a check, F + 33 restoring divider steps and a load.
// Each Newton step runs multiplier states S_M0 to S_M10, a slope check, F + 33 divider
// steps and an update; y(t) then reuses S_M0 to S_M7, then the final scale and a
// saturating sum. NEWTON_STEPS (default 10) bounds the loop; the slope check can end it sooner.
// The curve math shares one multiplier and one divider step unit; the final scale
// has its own multiplier.
// Reset is synchronous and active low; s_axis_tready is low while an item is busy
// and while a result waits in the output register.
module cubic_bezier_easing_interpolator #(
    parameter int unsigned NEWTON_STEPS = 10,
    parameter int unsigned FRAC_BITS    = 24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // elapsed, duration, start, end
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // eased_value
    input  wire logic         i_cfg_we,
    input  wire logic [cbe_pkg::IdxW-1:0] i_cfg_idx,
    input  wire logic [cbe_pkg::RegW-1:0] i_cfg_data
);
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned W  = F + 8;               // signed working width
    localparam int unsigned MW = 2 * W;
    localparam int unsigned SW = $clog2(NEWTON_STEPS + 1);
    localparam int unsigned DW = F + 33;              // dividend/quotient width
    localparam int unsigned CW = $clog2(DW + 1);
    localparam longint EpsRaw = ((longint'(1) << F) + 500000) / 1000000;
    localparam longint EpsL   = (EpsRaw < 1) ? 1 : EpsRaw;
    localparam logic signed [W-1:0] Qone = W'(longint'(1) << F);
    localparam logic signed [W-1:0] Eps  = W'(EpsL);

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_UDIV, S_UEND, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_M6, S_M7, S_M8, S_M9, S_M10, S_M11, S_DCHK, S_QDIV, S_QEND,
        S_SCALE, S_SUM, S_OUT
    } t_state;

    t_state r_state;
    logic [cbe_pkg::RegW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [31:0] r_el, r_st, r_en;
    logic [30:0] r_dur;
    logic signed [W-1:0] r_u, r_t, r_p1, r_p2, r_s, r_a, r_b, r_c, r_d, r_acc;
    logic r_ymode;
    logic [SW-1:0] r_step;
    logic [DW-1:0] r_quo;
    logic [DW:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic r_qneg;
    logic signed [32:0] r_delta;
    logic signed [65:0] r_res;
    logic [31:0] r_out;

    // Shared multiplier: sign-magnitude, truncated toward zero.
    logic signed [W-1:0] n_ma, n_mb, w_mul;
    logic [W-1:0] w_maa, w_mab;
    logic [MW-1:0] w_mp;
    always_comb begin
        w_maa = n_ma[W-1] ? W'(-n_ma) : n_ma;
        w_mab = n_mb[W-1] ? W'(-n_mb) : n_mb;
        w_mp  = MW'(w_maa) * MW'(w_mab);
        w_mul = (n_ma[W-1] ^ n_mb[W-1]) ? -W'(w_mp >> F) : W'(w_mp >> F);
    end

    function automatic logic signed [W-1:0] widen(input logic [cbe_pkg::RegW-1:0] r);
        logic [W+16:0] v;
        v = (W+17)'(r) << F;
        return W'(v >> 16);
    endfunction

    // Divider step.
    logic [DW:0] w_trial;
    assign w_trial = {r_rem[DW-1:0], r_quo[DW-1]};

    logic signed [W-1:0] w_err;
    assign w_err = r_acc - r_u;

    always_comb begin
        case (r_state)
            S_M0:  begin n_ma = r_s;   n_mb = r_s;   end  // s*s
            S_M1:  begin n_ma = r_a;   n_mb = r_t;   end  // s*s*t
            S_M2:  begin n_ma = r_b;   n_mb = r_p1;  end
            S_M3:  begin n_ma = r_s;   n_mb = r_t;   end  // s*t
            S_M4:  begin n_ma = r_c;   n_mb = r_t;   end  // s*t*t
            S_M5:  begin n_ma = r_b;   n_mb = r_p2;  end
            S_M6:  begin n_ma = r_t;   n_mb = r_t;   end  // t*t
            S_M7:  begin n_ma = r_d;   n_mb = r_t;   end
            S_M8:  begin n_ma = r_a;   n_mb = r_p1;  end  // slope terms
            S_M9:  begin n_ma = r_c;   n_mb = r_p2 - r_p1; end
            S_M10: begin n_ma = r_d;   n_mb = Qone - r_p2; end
            default: begin n_ma = '0;  n_mb = '0;    end
        endcase
    end

    logic [W-1:0] w_emag, w_dmag;
    assign w_emag = w_err[W-1] ? W'(-w_err) : w_err;
    assign w_dmag = r_b[W-1] ? W'(-r_b) : r_b;

    logic [63:0] w_dmag_d, w_ymag;
    logic [32:0] w_delmag;
    logic [65:0] w_m;
    assign w_delmag = r_delta[32] ? 33'(-r_delta) : 33'(r_delta);
    assign w_ymag   = r_acc[W-1] ? 64'(W'(-r_acc)) : 64'(r_acc);
    assign w_m      = 66'(w_delmag) * 66'(w_ymag);
    assign w_dmag_d = 64'(w_dmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_x1 <= cbe_pkg::ResetX1; r_y1 <= cbe_pkg::ResetY1;
            r_x2 <= cbe_pkg::ResetX2; r_y2 <= cbe_pkg::ResetY2;
            r_out <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cbe_pkg::RegX1: r_x1 <= i_cfg_data;
                    cbe_pkg::RegY1: r_y1 <= i_cfg_data;
                    cbe_pkg::RegX2: r_x2 <= i_cfg_data;
                    cbe_pkg::RegY2: r_y2 <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_el  <= s_axis_tdata[31:0];
                    r_dur <= s_axis_tdata[62:32];
                    r_st  <= s_axis_tdata[94:63];
                    r_en  <= s_axis_tdata[126:95];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_delta <= 33'(r_en) - 33'(r_st);
                    if (r_el <= 0) begin
                        r_out <= r_st; r_state <= S_OUT;
                    end else if (33'(r_el) >= 33'(r_dur)) begin
                        r_out <= r_en; r_state <= S_OUT;
                    end else begin
                        r_quo <= DW'(r_el) << F;
                        r_rem <= '0;
                        r_den <= DW'(r_dur);
                        r_cnt <= CW'(DW);
                        r_state <= S_UDIV;
                    end
                end
                S_UDIV, S_QDIV: begin
                    if (w_trial >= {1'b0, r_den}) begin
                        r_rem <= w_trial - {1'b0, r_den};
                        r_quo <= {r_quo[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[DW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1))
                        r_state <= (r_state == S_UDIV) ? S_UEND : S_QEND;
                end
                S_UEND: begin
                    r_u <= W'(r_quo);
                    r_t <= W'(r_quo);
                    r_s <= Qone - W'(r_quo);
                    r_p1 <= widen(r_x1); r_p2 <= widen(r_x2);
                    r_ymode <= 1'b0;
                    r_step <= '0;
                    if (r_quo == '0) begin
                        r_acc <= '0; r_state <= S_SCALE;
                    end else if (NEWTON_STEPS == 0) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_M0;
                    end
                end
                S_M0: begin r_a <= w_mul; r_acc <= '0; r_state <= S_M1; end
                S_M1: begin r_b <= w_mul; r_state <= S_M2; end
                S_M2: begin r_acc <= r_acc + W'(3) * w_mul; r_state <= S_M3; end
                S_M3: begin r_c <= w_mul; r_state <= S_M4; end
                S_M4: begin r_b <= w_mul; r_state <= S_M5; end
                S_M5: begin r_acc <= r_acc + W'(3) * w_mul; r_state <= S_M6; end
                S_M6: begin r_d <= w_mul; r_state <= S_M7; end
                S_M7: begin
                    r_acc <= r_acc + w_mul;
                    r_state <= r_ymode ? S_SCALE : S_M8;
                end
                S_M8: begin
                    // r_a still holds s*s, r_c holds s*t and r_d holds t*t.
                    r_b <= W'(3) * w_mul; r_state <= S_M9;
                end
                S_M9: begin r_b <= r_b + W'(6) * w_mul; r_state <= S_M10; end
                S_M10: begin r_b <= r_b + W'(3) * w_mul; r_state <= S_DCHK; end
                S_DCHK: begin
                    if (w_dmag < W'(Eps)) begin
                        r_p1 <= widen(r_y1); r_p2 <= widen(r_y2);
                        r_ymode <= 1'b1; r_state <= S_M0;
                    end else begin
                        r_qneg <= (w_err[W-1] == r_b[W-1]);
                        r_quo <= DW'(w_emag) << F;
                        r_rem <= '0;
                        r_den <= DW'(w_dmag_d);
                        r_cnt <= CW'(DW);
                        r_state <= S_QDIV;
                    end
                end
                S_QEND: begin
                    if (r_qneg) begin
                        if (r_quo >= DW'(r_t)) r_t <= '0;
                        else r_t <= r_t - W'(r_quo);
                        r_s <= (r_quo >= DW'(r_t)) ? Qone : r_s + W'(r_quo);
                    end else begin
                        if (r_quo >= DW'(Qone - r_t)) r_t <= Qone;
                        else r_t <= r_t + W'(r_quo);
                        r_s <= (r_quo >= DW'(Qone - r_t)) ? '0 : r_s - W'(r_quo);
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(NEWTON_STEPS - 1)) begin
                        r_p1 <= widen(r_y1); r_p2 <= widen(r_y2);
                        r_ymode <= 1'b1;
                    end
                    r_state <= S_M0;
                end
                S_SCALE: begin
                    if (r_delta[32] == r_acc[W-1] || r_acc == '0)
                        r_res <= 66'(r_st) + 66'((w_m + 66'(Qone >>> 1)) >> F);
                    else if (w_m <= 66'(Qone >>> 1))
                        r_res <= 66'(r_st);
                    else
                        r_res <= 66'(r_st) - 66'((w_m - 66'(Qone >>> 1)) >> F);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_res > 66'sd2147483647) r_out <= 32'h7FFFFFFF;
                    else if (r_res < -66'sd2147483648) r_out <= 32'h80000000;
                    else r_out <= r_res[31:0];
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;
endmodule
`default_nettype wire

// ----- rtl/core/cbe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_bezier_easing_interpolator_assert.svh"
module cbe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);
    // The block never takes a new item while a result is offered.
    `CBE_ASSERT_IMP(a_excl, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "ready while result held")
    // An accepted item is not followed immediately by a result.
    `CBE_ASSERT_NXT(a_lat, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result too early")
    // A stalled result keeps its value.
    `CBE_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
endmodule
bind cubic_bezier_easing_interpolator cbe_checker u_cbe_checker (.*);
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

class ease_scoreboard;
    bit [16:0] x1, y1, x2, y2;
    logic signed [31:0] expected_q[$];
    int errors;

    function new();
        x1 = cbe_pkg::ResetX1;
        y1 = cbe_pkg::ResetY1;
        x2 = cbe_pkg::ResetX2;
        y2 = cbe_pkg::ResetY2;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, bit [16:0] v);
        case (idx)
            cbe_pkg::RegX1: x1 = v;
            cbe_pkg::RegY1: y1 = v;
            cbe_pkg::RegX2: x2 = v;
            default: y2 = v;
        endcase
    endfunction

    function longint fmul(longint a, longint b);
        longint ma, mb, p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb) >>> 24;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function longint widen(bit [16:0] r);
        return longint'(r) << 8;
    endfunction

    function longint bez(longint t, longint p1, longint p2);
        longint s;
        s = (64'sd1 << 24) - t;
        return 3 * fmul(fmul(fmul(s, s), t), p1) + 3 * fmul(fmul(fmul(s, t), t), p2)
             + fmul(fmul(t, t), t);
    endfunction

    function longint bez_slope(longint t, longint p1, longint p2);
        longint s;
        s = (64'sd1 << 24) - t;
        return 3 * fmul(fmul(s, s), p1) + 6 * fmul(fmul(s, t), p2 - p1)
             + 3 * fmul(fmul(t, t), (64'sd1 << 24) - p2);
    endfunction

    function longint eased(logic signed [31:0] el, logic [30:0] dur,
                           logic signed [31:0] st, logic signed [31:0] en);
        longint one, u, t, d, err, y, delta, q, res, px1, px2;
        longint unsigned m, qq;
        one = 64'sd1 << 24;
        if (el <= 0) return st;
        if (longint'(el) >= longint'(dur)) return en;
        u = (longint'(el) << 24) / longint'(dur);
        y = 0;
        if (u > 0) begin
            px1 = widen(x1);
            px2 = widen(x2);
            t = u;
            for (int i = 0; i < 10; i++) begin
                d = bez_slope(t, px1, px2);
                if (((d < 0) ? -d : d) < 17) break;
                err = bez(t, px1, px2) - u;
                qq = (longint'((err < 0) ? -err : err) << 24) / ((d < 0) ? -d : d);
                if ((err < 0) == (d < 0))
                    t = (qq >= t) ? 0 : t - longint'(qq);
                else
                    t = (qq >= one - t) ? one : t + longint'(qq);
            end
            y = bez(t, widen(y1), widen(y2));
        end
        delta = longint'(en) - longint'(st);
        m = longint'((delta < 0) ? -delta : delta) * longint'((y < 0) ? -y : y);
        if ((delta < 0) == (y < 0) || delta == 0 || y == 0)
            q = longint'((m + (one >> 1)) >> 24);
        else if (m <= (one >> 1))
            q = 0;
        else
            q = -longint'((m - (one >> 1)) >> 24);
        res = longint'(st) + q;
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res;
    endfunction

    function void note_input(logic [127:0] data);
        expected_q.push_back(32'(eased(data[31:0], data[62:32], data[94:63], data[126:95])));
    endfunction

    function void check_result(logic [31:0] got);
        logic signed [31:0] want;
        if (expected_q.size() == 0) begin
            $error("eased_value: unexpected result %0d", $signed(got));
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got !== want) begin
            $error("eased_value: expected %0d actual %0d", want, $signed(got));
            errors++;
        end
    endfunction
endclass

module tb;
    logic i_clk = 0, i_rst_n = 0;
    logic s_axis_tvalid = 0, s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic m_axis_tvalid, m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic i_cfg_we = 0;
    logic [cbe_pkg::IdxW-1:0] i_cfg_idx = '0;
    logic [cbe_pkg::RegW-1:0] i_cfg_data = '0;
    ease_scoreboard sb = new();
    bit calm = 0;

    cubic_bezier_easing_interpolator dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls, except during the calm stretch.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        m_axis_tready <= calm || ($urandom_range(99) >= 37);
    end

    // The write enable stays high between back-to-back writes; the caller drops it.
    task automatic write_reg(logic [1:0] idx, bit [16:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    // tvalid stays high after a transaction until the next idle cycle or drain.
    task automatic send_item(logic [31:0] el, logic [30:0] dur, logic [31:0] st,
                             logic [31:0] en);
        while (!calm && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {1'b0, en, st, dur, el};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input({1'b0, en, st, dur, el});
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic rand_item(int mode);
        logic [30:0] dur;
        logic [31:0] el;
        case ($urandom_range(9))
            0: dur = 31'($urandom());
            1, 2: dur = 31'($urandom_range(1, 3));
            default: dur = 31'($urandom_range(1, 5000));
        endcase
        case (mode == 1 ? 9 : $urandom_range(9))
            0: el = $urandom();
            1: el = -$signed({1'b0, 31'($urandom())});
            2: el = dur + $urandom_range(0, 3);
            default: el = (dur == 0) ? 0 : $urandom_range(0, dur);
        endcase
        send_item(el, dur, $urandom(), ($urandom_range(3) == 0) ? $urandom()
                  : $urandom_range(0, 2000));
    endtask

    initial begin
        bit [16:0] sets[4][4];
        sets = '{'{0, 0, 0, 0}, '{65536, 65536, 65536, 65536},
                 '{131071, 131071, 131071, 0}, '{0, 131071, 65536, 0}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: boundaries of time, duration and value range.
        send_item(0, 100, 32'h8000_0000, 32'h7fff_ffff);
        send_item(32'h8000_0000, 100, 5, 9);
        send_item(32'h7fff_ffff, 31'h7fff_ffff, 1, 2);
        send_item(100, 100, 1, 2);
        send_item(5, 0, 1, 2);
        send_item(1, 31'h7fff_ffff, 7, 1000);
        send_item(50, 100, 32'h8000_0000, 32'h7fff_ffff);
        send_item(50, 100, 32'h7fff_ffff, 32'h8000_0000);
        send_item(99, 100, 32'h7fff_fff0, 32'h7fff_ffff);
        send_item(1, 2, -1000, 1000);
        send_item(32'h7fff_fffe, 31'h7fff_ffff, 0, 32'hffff_ffff);
        send_item(32'hffff_ffff, 31'h7fff_ffff, 3, 4);
        // Pause until all results are back.
        drain();
        for (int p = 0; p < 5; p++) begin
            calm = (p == 2);
            for (int i = 0; i < 150; i++) rand_item(0);
            drain();
            if (p < 4) begin
                for (int r = 0; r < 4; r++)
                    write_reg(2'(r), (p == 3) ? 17'($urandom_range(0, 131071))
                                              : sets[p][r]);
                i_cfg_we <= 0;
            end
            // Random control points with values near the extremes.
            if (p == 3)
                for (int i = 0; i < 10; i++)
                    send_item($urandom_range(1, 99), 100, 32'h7fff_ff00, 32'h8000_0000);
        end
        drain();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- cubic_bezier_easing_interpolator.f -----
+incdir+rtl/core
rtl/core/cbe_pkg.sv
rtl/core/cubic_bezier_easing_interpolator.sv
rtl/core/cbe_checker.sv
dv/tb.sv
